// ===== hdl/xrng_pkg.sv =====
// Shared constants, types and state encodings for the xoshiro128++ bounded RNG.
package xrng_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] MIX_INC      = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 32'hC2B2_AE35;
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'h1D2C_6A5F;
  localparam logic [WORD_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] SIGN_BIT     = 32'h8000_0000;

  // request codes
  localparam logic CMD_RAW   = 1'b0;
  localparam logic CMD_RANGE = 1'b1;

  // seed expansion phases
  typedef enum logic [2:0] {
    SP_IDLE,
    SP_ADD,
    SP_MULA,
    SP_MULB,
    SP_OUT,
    SP_FIN
  } seed_phase_t;

  // main sequencer states
  typedef enum logic [2:0] {
    ST_RESEED,
    ST_SEED,
    ST_IDLE,
    ST_DECODE,
    ST_LIMIT,
    ST_DRAW,
    ST_MOD,
    ST_DELIVER
  } ctl_state_t;

  // state word writes from the seed expander
  typedef struct packed {
    logic              en;
    logic [1:0]        idx;
    logic [WORD_W-1:0] data;
    logic              done;
  } seed_wr_t;

endpackage

// ===== hdl/xrng_div.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
module xrng_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [xrng_pkg::WORD_W-1:0] dividend,
  input  logic [xrng_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [xrng_pkg::WORD_W-1:0] rem
);
  import xrng_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] dq;
  logic [WORD_W-1:0] divr;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem, dq[WORD_W-1]};
  assign diff  = trial - {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= dividend;
      divr <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dq <= {dq[WORD_W-2:0], 1'b0};
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/xrng_seeder.sv =====
// SplitMix32-style seed expander sharing one 32x32 multiplier over the steps.
module xrng_seeder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [xrng_pkg::WORD_W-1:0] seed_val,
  output xrng_pkg::seed_wr_t          wr
);
  import xrng_pkg::*;

  seed_phase_t       ph, ph_next;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] z;
  logic [1:0]        idx;
  logic [WORD_W-1:0] acc_sum;
  logic [WORD_W-1:0] mul_in;
  logic [WORD_W-1:0] mul_k;
  logic [WORD_W-1:0] prod;

  assign acc_sum = acc + MIX_INC;
  assign mul_in  = (ph == SP_MULA) ? z : (z ^ (z >> 13));
  assign mul_k   = (ph == SP_MULA) ? MIX_MUL_A : MIX_MUL_B;
  assign prod    = mul_in * mul_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= SP_IDLE;
    end else begin
      ph <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ph)
      SP_IDLE: begin
        if (start) begin
          acc <= (seed_val != '0) ? seed_val : SEED_DEFAULT;
          idx <= '0;
        end
      end
      SP_ADD: begin
        acc <= acc_sum;
        z   <= acc_sum ^ (acc_sum >> 16);
      end
      SP_MULA, SP_MULB: begin
        z <= prod;
      end
      SP_OUT: begin
        idx <= idx + 1'b1;
      end
      SP_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ph_next = ph;
    wr.en   = 1'b0;
    wr.idx  = idx;
    wr.data = z ^ (z >> 16);
    wr.done = 1'b0;
    unique case (ph)
      SP_IDLE: if (start) ph_next = SP_ADD;
      SP_ADD:  ph_next = SP_MULA;
      SP_MULA: ph_next = SP_MULB;
      SP_MULB: ph_next = SP_OUT;
      SP_OUT: begin
        wr.en   = 1'b1;
        ph_next = (idx == 2'd3) ? SP_FIN : SP_ADD;
      end
      SP_FIN: begin
        wr.done = 1'b1;
        ph_next = SP_IDLE;
      end
      default: ph_next = SP_IDLE;
    endcase
  end

endmodule

// ===== hdl/xoshiro128pp_bounded_rng.sv =====
// Top level of the xoshiro128++ generator with raw and bounded-range draws.
//
// Each request word gives one result word. A raw request (cmd 0) or a range
// whose span is the full 2^32 loads its result at decode and goes straight
// to delivery; an empty or inverted range (high_bound <= low_bound) returns
// low_bound the same way without advancing the generator. A proper range
// draw first finds the span's rejection limit, then draws words until one
// falls below that limit, then reduces that word: the limit and the final
// reduction each pass through the shared restoring remainder unit, which
// sets the rate. After reset and after each seed write the state is
// re-expanded; no request or seed write is taken meanwhile. Writing seed
// reseeds immediately; seed 0 selects the built-in default. A finished
// result sits in the output register while the next request is accepted.
module xoshiro128pp_bounded_rng (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic signed [xrng_pkg::WORD_W-1:0] low_bound,
  input  logic signed [xrng_pkg::WORD_W-1:0] high_bound,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [xrng_pkg::WORD_W-1:0] value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [xrng_pkg::WORD_W-1:0] seed
);
  import xrng_pkg::*;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  ctl_state_t        st, st_next;
  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] s0, s1, s2, s3;
  logic              cmd_r;
  logic [WORD_W-1:0] lo_r, hi_r;
  logic [WORD_W-1:0] span_r;
  logic [WORD_W-1:0] limit_r;
  logic [WORD_W-1:0] res_r;

  // generator step, combinational from the state words
  logic [WORD_W-1:0] nw;
  logic [WORD_W-1:0] t0, t1, t2, t3;

  // decode of a registered request
  logic              empty_rng;
  logic [WORD_W-1:0] span;

  // control
  logic              in_fire, cfg_fire, deliver;
  logic              adv;
  logic              seed_start;
  logic              div_start;
  logic [WORD_W-1:0] div_a, div_b;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;
  seed_wr_t          seed_wr;

  assign nw = rotl(s0 + s3, 7) + s0;
  assign t2 = s2 ^ s0;
  assign t3 = s3 ^ s1;
  assign t1 = s1 ^ t2;
  assign t0 = s0 ^ t3;

  assign empty_rng = (hi_r ^ SIGN_BIT) <= (lo_r ^ SIGN_BIT);
  assign span      = hi_r - lo_r + 1'b1;

  assign cfg_ready = (st == ST_IDLE);
  assign in_ready  = (st == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  xrng_seeder u_seeder (
    .clk      (clk),
    .rst      (rst),
    .start    (seed_start),
    .seed_val (seed_reg),
    .wr       (seed_wr)
  );

  xrng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESEED;
    end else begin
      st <= st_next;
    end
  end

  // sequencer: next state and per-cycle strobes
  always_comb begin
    st_next    = st;
    adv        = 1'b0;
    seed_start = 1'b0;
    div_start  = 1'b0;
    div_a      = ALL_ONES;
    div_b      = span;
    deliver    = 1'b0;
    unique case (st)
      ST_RESEED: begin
        seed_start = 1'b1;
        st_next    = ST_SEED;
      end
      ST_SEED: begin
        if (seed_wr.done) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        priority if (cfg_fire) st_next = ST_RESEED;
        else if (in_fire)      st_next = ST_DECODE;
        else                   st_next = ST_IDLE;
      end
      ST_DECODE: begin
        priority if (cmd_r == CMD_RAW) begin
          adv     = 1'b1;
          st_next = ST_DELIVER;
        end else if (empty_rng) begin
          st_next = ST_DELIVER;
        end else if (span == '0) begin
          adv     = 1'b1;
          st_next = ST_DELIVER;
        end else begin
          div_start = 1'b1;
          st_next   = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (div_done) st_next = ST_DRAW;
      end
      ST_DRAW: begin
        adv   = 1'b1;
        div_a = nw;
        div_b = span_r;
        if (nw < limit_r) begin
          div_start = 1'b1;
          st_next   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) st_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid || out_ready) begin
          deliver = 1'b1;
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_RESEED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= '0;
    end else if (cfg_fire) begin
      seed_reg <= seed;
    end
  end

  // generator state: written by the expander, or stepped once per drawn word
  always_ff @(posedge clk) begin
    if (seed_wr.en) begin
      unique case (seed_wr.idx)
        2'd0: s0 <= seed_wr.data;
        2'd1: s1 <= seed_wr.data;
        2'd2: s2 <= seed_wr.data;
        2'd3: s3 <= seed_wr.data;
        default: s0 <= seed_wr.data;
      endcase
    end else if (seed_wr.done) begin
      // all-zero state would lock up the generator
      if ((s0 | s1 | s2 | s3) == '0) s0 <= WORD_W'(1);
    end else if (adv) begin
      s0 <= t0;
      s1 <= t1;
      s2 <= t2 ^ (s1 << 9);
      s3 <= rotl(t3, 11);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd;
      lo_r  <= WORD_W'(unsigned'(low_bound));
      hi_r  <= WORD_W'(unsigned'(high_bound));
    end
    if (st == ST_DECODE) begin
      span_r <= span;
      res_r  <= (cmd_r == CMD_RANGE && empty_rng) ? lo_r : nw;
    end
    if (st == ST_LIMIT && div_done) begin
      limit_r <= ALL_ONES - div_rem;
    end
    if (st == ST_MOD && div_done) begin
      res_r <= lo_r + div_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) value <= res_r;
  end

`ifndef SYNTH
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == ST_IDLE |-> (s0 | s1 | s2 | s3) != '0)
    else $error("generator state is all zero while idle");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == ST_LIMIT || st == ST_MOD))
    else $error("remainder unit finished outside a wait state");

  a_mod_in_span: assert property (@(posedge clk) disable iff (rst)
    (st == ST_MOD && div_done) |-> div_rem < span_r)
    else $error("reduced word not below span");

  a_cfg_reseeds: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> st == ST_RESEED)
    else $error("seed write did not restart expansion");
`endif

endmodule
